>>> sv/med_pkg.sv
// package for the mesh edge dedup table
// word types of both channels and the request/response words of the scan unit
// no dependencies
package med_pkg;

  // widest vertex and table index that the scan request/response words carry
  localparam int unsigned MAX_VERTEX_BITS = 32;
  localparam int unsigned MAX_INDEX_BITS  = 16;

  typedef struct packed {
    logic [15:0] point_vertex;
    logic        facet_end;
    logic        mesh_start;
  } in_word_t;

  typedef struct packed {
    logic [9:0] edge_index;
    logic       edge_is_new;
    logic [7:0] point_slot;
    logic       table_full;
    logic       last_of_run;
  } out_word_t;

  typedef struct packed {
    logic                       start;
    logic                       clear;
    logic [MAX_VERTEX_BITS-1:0] a;
    logic [MAX_VERTEX_BITS-1:0] b;
  } scan_req_t;

  typedef struct packed {
    logic                      done;
    logic                      is_new;
    logic                      full;
    logic [MAX_INDEX_BITS-1:0] index;
  } scan_rsp_t;

endpackage

>>> sv/med_edge_scan.sv
// edge table memory with its lookup-and-append scan unit
// one lookup scans stored pairs one per cycle, appends on a miss
// depends on med_pkg
module med_edge_scan import med_pkg::*; #(
  parameter int unsigned EDGE_DEPTH  = 1024,
  parameter int unsigned VERTEX_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  scan_req_t req,
  output scan_rsp_t rsp
);

  localparam int unsigned IW = $clog2(EDGE_DEPTH);
  localparam int unsigned CW = $clog2(EDGE_DEPTH + 1);
  localparam int unsigned PW = 2 * VERTEX_BITS;

  typedef enum logic [1:0] {
    SC_IDLE = 2'b01,
    SC_SCAN = 2'b10
  } scan_state_t;

  scan_state_t            state;
  logic [PW-1:0]          mem [EDGE_DEPTH];
  logic [PW-1:0]          rdata;
  logic [CW-1:0]          count;
  logic [CW-1:0]          issue_idx;
  logic                   chk_valid;
  logic [IW-1:0]          chk_idx;
  logic [VERTEX_BITS-1:0] key_a;
  logic [VERTEX_BITS-1:0] key_b;
  logic                   done_q;
  logic                   new_q;
  logic                   full_q;
  logic [IW-1:0]          idx_q;

  logic [VERTEX_BITS-1:0] rd_a;
  logic [VERTEX_BITS-1:0] rd_b;
  logic                   hit;
  logic                   miss;
  logic                   room;
  logic                   rd_en;
  logic                   wr_en;

  always_comb begin
    rd_a  = rdata[PW-1:VERTEX_BITS];
    rd_b  = rdata[VERTEX_BITS-1:0];
    hit   = (state == SC_SCAN) && chk_valid &&
            (((rd_a == key_a) && (rd_b == key_b)) || ((rd_a == key_b) && (rd_b == key_a)));
    miss  = (state == SC_SCAN) && !chk_valid && (issue_idx == count);
    room  = count < CW'(EDGE_DEPTH);
    rd_en = (state == SC_SCAN) && !hit && (issue_idx < count);
    wr_en = miss && room;
  end

  // table storage, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count[IW-1:0]] <= {key_a, key_b};
    end
    if (rd_en) begin
      rdata <= mem[issue_idx[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= SC_IDLE;
      count     <= '0;
      chk_valid <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state)
        SC_IDLE: begin
          if (req.clear) begin
            count <= '0;
          end
          if (req.start) begin
            state     <= SC_SCAN;
            chk_valid <= 1'b0;
          end
        end
        SC_SCAN: begin
          if (hit || miss) begin
            done_q    <= 1'b1;
            chk_valid <= 1'b0;
            state     <= SC_IDLE;
            if (wr_en) begin
              count <= count + CW'(1);
            end
          end else begin
            chk_valid <= rd_en;
          end
        end
        default: begin
          state <= SC_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == SC_IDLE && req.start) begin
      key_a     <= req.a[VERTEX_BITS-1:0];
      key_b     <= req.b[VERTEX_BITS-1:0];
      issue_idx <= '0;
    end
    if (rd_en) begin
      issue_idx <= issue_idx + CW'(1);
      chk_idx   <= issue_idx[IW-1:0];
    end
    if (hit) begin
      idx_q  <= chk_idx;
      new_q  <= 1'b0;
      full_q <= 1'b0;
    end else if (miss) begin
      idx_q  <= room ? count[IW-1:0] : IW'(EDGE_DEPTH - 1);
      new_q  <= room;
      full_q <= !room;
    end
  end

  always_comb begin
    rsp.done   = done_q;
    rsp.is_new = new_q;
    rsp.full   = full_q;
    rsp.index  = MAX_INDEX_BITS'(idx_q);
  end

endmodule

>>> sv/mesh_edge_dedup_table_top.sv
// top level of the mesh edge dedup table
// facet tracking, edge sequencing and the output register
// depends on med_pkg and med_edge_scan
//
// usage
// - in channel (in_valid/in_ready/in_data): one facet point per word, with
//   facet_end marking the last point of a facet and mesh_start emptying the
//   edge table and opening a new facet before the point is handled
// - out channel (out_valid/out_ready/out_data): one word per edge formed,
//   zero, one or two per point; last_of_run marks the final word of a point
// - a point is taken only while no earlier point is still being worked on;
//   a finished word may still wait in the output register when it is taken
// - each edge lookup scans the stored pairs one per cycle through the table
//   memory read port, so its duration grows with the number of stored edges,
//   and a point needs up to two lookups
// - a new edge is appended in the same memory; a full table is not written
// - reset empties the table and the facet progress, no clearing pass is run:
//   entries beyond the fill count are never read
// - when the receiver stalls, the next edge lookup waits until the output
//   register is empty, so nothing is lost or reordered
module mesh_edge_dedup_table_top import med_pkg::*; #(
  parameter int unsigned EDGE_DEPTH       = 1024,
  parameter int unsigned VERTEX_BITS      = 16,
  parameter int unsigned MAX_FACET_POINTS = 256
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  localparam int unsigned SW = $clog2(MAX_FACET_POINTS);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_START1 = 5'b00010,
    ST_WAIT1  = 5'b00100,
    ST_START2 = 5'b01000,
    ST_WAIT2  = 5'b10000
  } state_t;

  state_t                 state;
  state_t                 state_next;

  // facet progress
  logic [VERTEX_BITS-1:0] facet_first;
  logic [VERTEX_BITS-1:0] previous_point;
  logic [SW-1:0]          points_seen;

  // edges pending for the current point
  logic [VERTEX_BITS-1:0] e1_a;
  logic [VERTEX_BITS-1:0] e1_b;
  logic [SW-1:0]          e1_slot;
  logic                   e1_last;
  logic                   e2_pend;
  logic [VERTEX_BITS-1:0] e2_a;
  logic [VERTEX_BITS-1:0] e2_b;
  logic [SW-1:0]          e2_slot;

  logic                   in_fire;
  logic [VERTEX_BITS-1:0] p;
  logic [SW-1:0]          slot;
  logic [VERTEX_BITS-1:0] first_eff;
  logic [31:0]            slot_wide;
  scan_req_t              req;
  scan_rsp_t              rsp;

  assign in_ready = (state == ST_IDLE);
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    // vertex bits above VERTEX_BITS are dropped
    p         = VERTEX_BITS'(32'(in_data.point_vertex));
    slot      = in_data.mesh_start ? '0 : points_seen;
    first_eff = (slot == '0) ? p : facet_first;
    slot_wide = (state == ST_WAIT1) ? 32'(e1_slot) : 32'(e2_slot);
  end

  // scan request: start a lookup only once the output register is free
  always_comb begin
    req.start = ((state == ST_START1) || (state == ST_START2)) && !out_valid;
    req.clear = in_fire && in_data.mesh_start;
    req.a     = (state == ST_START1) ? MAX_VERTEX_BITS'(e1_a) : MAX_VERTEX_BITS'(e2_a);
    req.b     = (state == ST_START1) ? MAX_VERTEX_BITS'(e1_b) : MAX_VERTEX_BITS'(e2_b);
  end

  med_edge_scan #(
    .EDGE_DEPTH  (EDGE_DEPTH),
    .VERTEX_BITS (VERTEX_BITS)
  ) u_scan (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          if (slot != '0) begin
            state_next = ST_START1;
          end else if (in_data.facet_end) begin
            state_next = ST_START2;
          end
        end
      end
      ST_START1: begin
        if (req.start) begin
          state_next = ST_WAIT1;
        end
      end
      ST_WAIT1: begin
        if (rsp.done) begin
          state_next = e2_pend ? ST_START2 : ST_IDLE;
        end
      end
      ST_START2: begin
        if (req.start) begin
          state_next = ST_WAIT2;
        end
      end
      ST_WAIT2: begin
        if (rsp.done) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      out_valid      <= 1'b0;
      facet_first    <= '0;
      previous_point <= '0;
      points_seen    <= '0;
    end else begin
      state <= state_next;
      if (rsp.done) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (in_fire) begin
        previous_point <= p;
        if (slot == '0) begin
          facet_first <= p;
        end
        // closing point restarts the facet, long facets share the last slot
        if (in_data.facet_end) begin
          points_seen <= '0;
        end else if (slot < SW'(MAX_FACET_POINTS - 1)) begin
          points_seen <= slot + SW'(1);
        end else begin
          points_seen <= slot;
        end
      end
    end
  end

  // edge operands captured with the point
  always_ff @(posedge clk) begin
    if (in_fire) begin
      e1_a    <= previous_point;
      e1_b    <= p;
      e1_slot <= slot - SW'(1);
      e1_last <= !in_data.facet_end;
      e2_pend <= in_data.facet_end;
      e2_a    <= p;
      e2_b    <= first_eff;
      e2_slot <= slot;
    end
  end

  // output register, loaded only while empty
  always_ff @(posedge clk) begin
    if (rsp.done) begin
      out_data.edge_index  <= rsp.index[9:0];
      out_data.edge_is_new <= rsp.is_new;
      out_data.point_slot  <= slot_wide[7:0];
      out_data.table_full  <= rsp.full;
      out_data.last_of_run <= (state == ST_WAIT1) ? e1_last : 1'b1;
    end
  end

  // scan results arrive only while an edge lookup is outstanding
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> ((state == ST_WAIT1) || (state == ST_WAIT2)))
    else $error("scan result outside a lookup");

  // a result never overwrites a word still waiting at the output
  a_done_empty: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> !out_valid)
    else $error("scan result while output register is busy");

  // a lookup never finishes in the cycle after its start
  a_scan_min: assert property (@(posedge clk) disable iff (rst)
    req.start |=> !rsp.done)
    else $error("scan finished too early");

  // a stored edge never reports a full table
  a_new_full: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> !(rsp.is_new && rsp.full))
    else $error("edge both new and table full");

endmodule
